@@ rtl/core/nawsd_pkg.sv @@
// shared types and constants of the nan-aware window standard deviation filter
package nawsd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_value;
		logic                          sample_missing;
	} in_word_t;

	typedef struct packed {
		logic [15:0] std_value;
		logic [15:0] center_row;
		logic [9:0]  center_col;
		logic        window_empty;
		logic [7:0]  valid_count;
		logic        frame_last;
	} out_word_t;

endpackage

@@ rtl/core/nan_aware_window_std_dev_top.sv @@
// top level of the nan-aware sliding window standard deviation filter
module nan_aware_window_std_dev_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  nawsd_pkg::in_word_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output nawsd_pkg::out_word_t                out_data,
	input  logic                                cfg_we,
	input  logic [nawsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [nawsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	// Pixels come in raster order, one word each. Every pixel is written to a line
	// store of MAX_WINDOW rows (no clearing pass: only rows of the current frame are
	// read). Once the row reaches the window height, the block gathers the column
	// above the pixel from the line store through its single read port, with a read
	// state and an accumulate state per earlier row, and shifts the column totals
	// into a chain of column cells; a running window total adds the new column and
	// drops the one leaving the chain. For a fully covered window the variance
	// (n*Q - S*S)/(n*n) goes through a bit-serial divider and a bit-serial square
	// root. A pixel above the first full window row is done once it is written; a
	// pixel that only feeds a column ends after the column shift and window total; a
	// pixel that closes a window goes on through the window total, the products and
	// the numerator, and, if the window holds samples, the 48-step divider and the
	// 24-step root at the default sizes, before the output load. An output stall
	// holds the block while it waits to load the output register. One word is
	// worked on at a time; the output register lets the next word in while a result
	// waits.
	import nawsd_pkg::*;

	// widths
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int SW   = $clog2(MAX_WINDOW + 1);
	localparam int SLW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNW  = SW;
	localparam int CSW  = SAMPLE_BITS + SW;
	localparam int CQW  = 2 * SAMPLE_BITS + SW;
	localparam int NW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int TSW  = SAMPLE_BITS + NW;
	localparam int TQW  = 2 * SAMPLE_BITS + NW;
	localparam int PW   = NW + TQW;
	localparam int DW   = 2 * NW;
	localparam int SQW  = PW + (PW % 2);
	localparam int RST_W   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RST_WIN = (MAX_WINDOW < 3) ? MAX_WINDOW : 3;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_ACC, S_WIN, S_MUL, S_SUB, S_DIV, S_SQRT, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [WW-1:0] width_q;
	logic [15:0]   height_q;
	logic [SW-1:0] win_q;

	// raster position of the next pixel
	logic [CW-1:0]  pos_col_q;
	logic [15:0]    pos_row_q;
	logic [SLW-1:0] pos_slot_q;

	// per-word context
	logic [CW-1:0]  cur_col_q;
	logic           do_win_q;
	logic           last_q;
	logic [15:0]    ctr_row_q;
	logic [15:0]    ctr_col_q;
	logic [SW-1:0]  rows_left_q;
	logic [SLW-1:0] rd_slot_q;

	// column gather
	logic [CNW-1:0]        col_n_q;
	logic signed [CSW-1:0] col_s_q;
	logic [CQW-1:0]        col_sq_q;

	// window totals and products
	logic [NW-1:0]         tot_n_q;
	logic signed [TSW-1:0] tot_s_q;
	logic [TQW-1:0]        tot_q_q;
	logic [PW-1:0]         prod_nq_q;
	logic [PW-1:0]         prod_ss_q;
	logic [DW-1:0]         nn_q;
	logic [15:0]           std_q;

	logic      out_valid_q;
	out_word_t out_data_q;

	// position helpers
	logic [SW-1:0]  ws_m1;
	logic [15:0]    ws16;
	logic [15:0]    ws_m1_16;
	logic [15:0]    half16;
	logic [15:0]    pcol16;
	logic [15:0]    ccol16;
	logic           do_col;
	logic           do_win;
	logic           accept;

	assign ws_m1    = win_q - 1'b1;
	assign ws16     = 16'(win_q);
	assign ws_m1_16 = 16'(ws_m1);
	assign half16   = 16'(win_q >> 1);
	assign pcol16   = 16'(pos_col_q);
	assign ccol16   = 16'(cur_col_q);
	assign do_col   = pos_row_q >= ws_m1_16;
	assign do_win   = do_col && (pcol16 >= ws_m1_16);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// config clamps
	logic [15:0] cfg_w16;
	logic [15:0] cfg_ws16;
	logic [15:0] cfg_w_cl;
	logic [15:0] cfg_ws_cl;

	assign cfg_w16  = {5'b0, cfg_data[10:0]};
	assign cfg_ws16 = {12'b0, cfg_data[3:0]};

	always_comb begin
		cfg_w_cl = cfg_w16;
		if (cfg_w16 == 16'd0) begin
			cfg_w_cl = 16'd1;
		end else if (cfg_w16 > 16'(MAX_WIDTH)) begin
			cfg_w_cl = 16'(MAX_WIDTH);
		end
		cfg_ws_cl = cfg_ws16;
		if (cfg_ws16 == 16'd0) begin
			cfg_ws_cl = 16'd1;
		end else if (cfg_ws16 > 16'(MAX_WINDOW)) begin
			cfg_ws_cl = 16'(MAX_WINDOW);
		end
	end

	// sample contributions: the new pixel and the line store read
	logic [SAMPLE_BITS:0]              rd_data;
	logic signed [SAMPLE_BITS-1:0]     rd_val;
	logic signed [2*SAMPLE_BITS-1:0]   in_sq;
	logic signed [2*SAMPLE_BITS-1:0]   rd_sq;

	assign rd_val = rd_data[SAMPLE_BITS-1:0];
	assign in_sq  = in_data.sample_value * in_data.sample_value;
	assign rd_sq  = rd_val * rd_val;

	nawsd_line #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW),
		.CW        (CW),
		.SLW       (SLW)
	) u_line (
		.clk    (clk),
		.wr_en  (accept),
		.wr_slot(pos_slot_q),
		.wr_col (pos_col_q),
		.wr_data({in_data.sample_missing, in_data.sample_value}),
		.rd_slot(rd_slot_q),
		.rd_col (cur_col_q),
		.rd_data(rd_data)
	);

	// chain of column cells, newest column in cell 0
	logic [CNW-1:0]        cell_n [MAX_WINDOW];
	logic signed [CSW-1:0] cell_s [MAX_WINDOW];
	logic [CQW-1:0]        cell_q [MAX_WINDOW];
	logic                  shift;

	assign shift = (state_q == S_WIN);

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		if (g == 0) begin : g_head
			nawsd_cell #(.CNW(CNW), .CSW(CSW), .CQW(CQW)) u_cell (
				.clk  (clk),
				.shift(shift),
				.in_n (col_n_q),
				.in_s (col_s_q),
				.in_q (col_sq_q),
				.out_n(cell_n[g]),
				.out_s(cell_s[g]),
				.out_q(cell_q[g])
			);
		end else begin : g_body
			nawsd_cell #(.CNW(CNW), .CSW(CSW), .CQW(CQW)) u_cell (
				.clk  (clk),
				.shift(shift),
				.in_n (cell_n[g-1]),
				.in_s (cell_s[g-1]),
				.in_q (cell_q[g-1]),
				.out_n(cell_n[g]),
				.out_s(cell_s[g]),
				.out_q(cell_q[g])
			);
		end
	end

	// column leaving the window: the one window_size columns back
	logic [SLW-1:0]        leave_idx;
	logic                  leave_en;
	logic [NW-1:0]         leave_n;
	logic signed [TSW-1:0] leave_s;
	logic [TQW-1:0]        leave_q;

	assign leave_idx = ws_m1[SLW-1:0];
	assign leave_en  = ccol16 >= ws16;
	assign leave_n   = leave_en ? NW'(cell_n[leave_idx]) : '0;
	assign leave_s   = leave_en ? TSW'(cell_s[leave_idx]) : '0;
	assign leave_q   = leave_en ? TQW'(cell_q[leave_idx]) : '0;

	// variance numerator and the two serial units
	logic [TSW-1:0] abs_s;
	logic [PW-1:0]  num;
	logic           div_start;
	logic           div_done;
	logic [PW-1:0]  quo;
	logic           sqrt_start;
	logic           sqrt_done;
	logic [SQW/2-1:0] root;
	logic [SQW/2+15:0] root_ext;

	assign abs_s      = (tot_s_q < 0) ? TSW'(-tot_s_q) : TSW'(tot_s_q);
	assign num        = prod_nq_q - prod_ss_q;
	assign div_start  = (state_q == S_SUB) && (tot_n_q != '0);
	assign sqrt_start = (state_q == S_DIV) && div_done;
	assign root_ext   = {16'b0, root};

	nawsd_div #(.NUM_W(PW), .DEN_W(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (nn_q),
		.done  (div_done),
		.quo   (quo)
	);

	nawsd_sqrt #(.IN_W(SQW)) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.val   (SQW'(quo)),
		.done  (sqrt_done),
		.root  (root)
	);

	// result fields at the output widths
	logic [NW+7:0] n_ext;
	logic          out_free;

	assign n_ext    = {8'b0, tot_n_q};
	assign out_free = !out_valid_q || !out_stall;

	// control: position, configuration, sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WW'(RST_W);
			height_q    <= 16'd1024;
			win_q       <= SW'(RST_WIN);
			pos_col_q   <= '0;
			pos_row_q   <= '0;
			pos_slot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// word taken and no new one loaded in the same cycle
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH: width_q <= cfg_w_cl[WW-1:0];
					CFG_IMAGE_HEIGHT: height_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
					CFG_WINDOW_SIZE: win_q <= cfg_ws_cl[SW-1:0];
					default: ;
				endcase
				// any known register restarts the frame
				if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
					cfg_index == CFG_WINDOW_SIZE) begin
					pos_col_q  <= '0;
					pos_row_q  <= '0;
					pos_slot_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// advance the raster position
						if (pcol16 == 16'(width_q) - 16'd1) begin
							pos_col_q <= '0;
							if (pos_row_q == height_q - 16'd1) begin
								pos_row_q  <= '0;
								pos_slot_q <= '0;
							end else begin
								pos_row_q  <= pos_row_q + 16'd1;
								pos_slot_q <= (pos_slot_q == SLW'(MAX_WINDOW - 1)) ?
									'0 : pos_slot_q + 1'b1;
							end
						end else begin
							pos_col_q <= pos_col_q + 1'b1;
						end
						if (do_col) begin
							state_q <= (ws_m1 == '0) ? S_WIN : S_READ;
						end
					end
				end
				S_READ: state_q <= S_ACC;
				S_ACC: state_q <= (rows_left_q == SW'(1)) ? S_WIN : S_READ;
				S_WIN: state_q <= do_win_q ? S_MUL : S_IDLE;
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= (tot_n_q == '0) ? S_OUT : S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cur_col_q   <= pos_col_q;
					do_win_q    <= do_win;
					last_q      <= (pos_row_q == height_q - 16'd1) &&
						(pcol16 == 16'(width_q) - 16'd1);
					ctr_row_q   <= pos_row_q - ws_m1_16 + half16;
					ctr_col_q   <= pcol16 - ws_m1_16 + half16;
					rows_left_q <= ws_m1;
					rd_slot_q   <= (pos_slot_q == '0) ? SLW'(MAX_WINDOW - 1) :
						pos_slot_q - 1'b1;
					// column starts with the new pixel itself
					if (in_data.sample_missing) begin
						col_n_q  <= '0;
						col_s_q  <= '0;
						col_sq_q <= '0;
					end else begin
						col_n_q  <= CNW'(1);
						col_s_q  <= CSW'(in_data.sample_value);
						col_sq_q <= CQW'(unsigned'(in_sq));
					end
				end
			end
			S_ACC: begin
				rows_left_q <= rows_left_q - 1'b1;
				rd_slot_q   <= (rd_slot_q == '0) ? SLW'(MAX_WINDOW - 1) : rd_slot_q - 1'b1;
				if (!rd_data[SAMPLE_BITS]) begin
					col_n_q  <= col_n_q + 1'b1;
					col_s_q  <= col_s_q + CSW'(rd_val);
					col_sq_q <= col_sq_q + CQW'(unsigned'(rd_sq));
				end
			end
			S_WIN: begin
				if (cur_col_q == '0) begin
					tot_n_q <= NW'(col_n_q);
					tot_s_q <= TSW'(col_s_q);
					tot_q_q <= TQW'(col_sq_q);
				end else begin
					tot_n_q <= tot_n_q + NW'(col_n_q) - leave_n;
					tot_s_q <= tot_s_q + TSW'(col_s_q) - leave_s;
					tot_q_q <= tot_q_q + TQW'(col_sq_q) - leave_q;
				end
			end
			S_MUL: begin
				prod_nq_q <= PW'(tot_n_q) * PW'(tot_q_q);
				prod_ss_q <= PW'(abs_s) * PW'(abs_s);
				nn_q      <= DW'(tot_n_q) * DW'(tot_n_q);
			end
			S_SUB: begin
				std_q <= '0;
			end
			S_SQRT: begin
				if (sqrt_done) begin
					std_q <= root_ext[15:0];
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_data_q.std_value    <= std_q;
					out_data_q.center_row   <= ctr_row_q;
					out_data_q.center_col   <= ctr_col_q[9:0];
					out_data_q.window_empty <= (tot_n_q == '0);
					out_data_q.valid_count  <= n_ext[7:0];
					out_data_q.frame_last   <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/core/nawsd_cell.sv @@
// one column cell of the window chain: holds a column's count, sum and sum of squares
module nawsd_cell #(
	parameter int CNW = 4,
	parameter int CSW = 20,
	parameter int CQW = 36
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic [CNW-1:0]        in_n,
	input  logic signed [CSW-1:0] in_s,
	input  logic [CQW-1:0]        in_q,
	output logic [CNW-1:0]        out_n,
	output logic signed [CSW-1:0] out_s,
	output logic [CQW-1:0]        out_q
);

	logic [CNW-1:0]        n_q;
	logic signed [CSW-1:0] s_q;
	logic [CQW-1:0]        q_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			n_q <= in_n;
			s_q <= in_s;
			q_q <= in_q;
		end
	end

	assign out_n = n_q;
	assign out_s = s_q;
	assign out_q = q_q;

endmodule

@@ rtl/core/nawsd_line.sv @@
// line store: the last rows of pixels, one write and one registered read per cycle
module nawsd_line #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 15,
	parameter int CW         = 10,
	parameter int SLW        = 4
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [SLW-1:0]              wr_slot,
	input  logic [CW-1:0]               wr_col,
	input  logic [nawsd_pkg::SAMPLE_BITS:0] wr_data,
	input  logic [SLW-1:0]              rd_slot,
	input  logic [CW-1:0]               rd_col,
	output logic [nawsd_pkg::SAMPLE_BITS:0] rd_data
);
	import nawsd_pkg::*;

	localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	logic [SAMPLE_BITS:0] mem [DEPTH];
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;

	assign wr_addr = AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(wr_col);
	assign rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/core/nawsd_div.sv @@
// restoring divider, one quotient bit per cycle
module nawsd_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int KW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [KW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic [DEN_W:0]   diff;

	assign sh   = {rem_q, quo_q[NUM_W-1]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/core/nawsd_sqrt.sv @@
// digit recurrence square root, one root bit per cycle, floored
module nawsd_sqrt #(
	parameter int IN_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   val,
	output logic              done,
	output logic [IN_W/2-1:0] root
);

	localparam int HW = IN_W / 2;
	localparam int KW = $clog2(HW + 1);

	logic [HW+1:0]   rem_q;
	logic [HW-1:0]   root_q;
	logic [IN_W-1:0] val_q;
	logic [KW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [HW+3:0]   sh;
	logic [HW+3:0]   trial;
	logic [HW+3:0]   diff;

	assign sh    = {rem_q, val_q[IN_W-1:IN_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(HW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= val;
		end else if (busy_q) begin
			val_q <= {val_q[IN_W-3:0], 2'b00};
			if (sh >= trial) begin
				rem_q  <= diff[HW+1:0];
				root_q <= {root_q[HW-2:0], 1'b1};
			end else begin
				rem_q  <= sh[HW+1:0];
				root_q <= {root_q[HW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/nawsd_check.sv @@
// port checker for the filter top level and its bind
module nawsd_check #(
	parameter int MAX_WINDOW = 15
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input nawsd_pkg::out_word_t out_data
);
	import nawsd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// empty window reports zero deviation and zero count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.window_empty |->
			out_data.std_value == 16'd0 && out_data.valid_count == 8'd0)
		else $error("empty window with nonzero fields");

	// a non-empty window has at least one sample
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.window_empty |-> out_data.valid_count != 8'd0)
		else $error("non-empty window with zero count");

	// count cannot exceed the largest window
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.valid_count) <= MAX_WINDOW * MAX_WINDOW)
		else $error("valid count above window area");

endmodule

bind nan_aware_window_std_dev_top nawsd_check #(.MAX_WINDOW(MAX_WINDOW)) u_nawsd_check (.*);
